### hw/rtl/sdtq_pkg.sv
// shared types and constants of the sorted deadline timer queue
`timescale 1ns / 1ps

package sdtq_pkg;

    localparam int ID_W       = 4;
    localparam int NUM_TIMERS = 16;
    localparam int DUR_W      = 32;
    localparam int TMO_W      = 32;

    localparam logic [TMO_W-1:0] TIMEOUT_EMPTY = 32'hFFFF_FFFF;
    localparam logic [TMO_W-1:0] TIMEOUT_MAX   = 32'hFFFF_FFFE;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STOP  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RUNNING   = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_RUNNG = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       insert;
        logic       remove;
        logic       report;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       running;
        logic       full;
    } t_dp_status;

endpackage

### hw/rtl/sdtq_if.sv
// command and result channel interfaces
`timescale 1ns / 1ps

interface sdtq_cmd_if #(
    parameter int TIME_BITS = 48
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   mode;
    logic [sdtq_pkg::ID_W-1:0]    timer_id;
    logic [sdtq_pkg::DUR_W-1:0]   duration_ms;
    logic [TIME_BITS-1:0]         now_ms;

    modport source (output valid, mode, timer_id, duration_ms, now_ms, input ready);
    modport sink   (input valid, mode, timer_id, duration_ms, now_ms, output ready);
endinterface

interface sdtq_res_if;
    logic                         valid;
    logic                         ready;
    logic [sdtq_pkg::TMO_W-1:0]   timeout_ms;
    logic [sdtq_pkg::ID_W-1:0]    head_id;
    logic                         queue_empty;
    logic [1:0]                   status;

    modport source (output valid, timeout_ms, head_id, queue_empty, status, input ready);
    modport sink   (input valid, timeout_ms, head_id, queue_empty, status, output ready);
endinterface

### hw/rtl/sdtq_ctrl.sv
// controller state machine: sequences load, queue update and result report
`timescale 1ns / 1ps

module sdtq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  sdtq_pkg::t_dp_status i_dp_status,
    output sdtq_pkg::t_dp_cmd    o_dp_cmd
);

    sdtq_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdtq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_status    <= sdtq_pkg::STATUS_OK;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_dp_cmd    = '0;
        unique case (r_state)
            sdtq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = sdtq_pkg::ST_EXEC;
                end
            end
            sdtq_pkg::ST_EXEC: begin
                n_status = sdtq_pkg::STATUS_OK;
                if (i_dp_status.mode == sdtq_pkg::MODE_START) begin
                    if (i_dp_status.running) begin
                        n_status = sdtq_pkg::STATUS_RUNNING;
                    end else if (i_dp_status.full) begin
                        n_status = sdtq_pkg::STATUS_FULL;
                    end else begin
                        o_dp_cmd.insert = 1'b1;
                    end
                end else if (i_dp_status.mode == sdtq_pkg::MODE_STOP) begin
                    if (i_dp_status.running) begin
                        o_dp_cmd.remove = 1'b1;
                    end else begin
                        n_status = sdtq_pkg::STATUS_NOT_RUNNG;
                    end
                end
                n_state = sdtq_pkg::ST_REPORT;
            end
            sdtq_pkg::ST_REPORT: begin
                o_dp_cmd.status = r_status;
                if (!r_out_valid || i_out_ready) begin
                    o_dp_cmd.report = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = sdtq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdtq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == sdtq_pkg::ST_EXEC))
        else $error("accepted item did not move to exec");

    a_insert_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.insert |-> (!i_dp_status.running && !i_dp_status.full))
        else $error("insert issued for running timer or full queue");

    a_remove_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.remove |-> i_dp_status.running)
        else $error("remove issued for idle timer");

    a_result_from_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == sdtq_pkg::ST_REPORT))
        else $error("result raised outside report state");

endmodule

### hw/rtl/sdtq_datapath.sv
// datapath: shift-register queue of deadlines, running mask and result register
`timescale 1ns / 1ps

module sdtq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_mode,
    input  logic [sdtq_pkg::ID_W-1:0]   i_timer_id,
    input  logic [sdtq_pkg::DUR_W-1:0]  i_duration_ms,
    input  logic [TIME_BITS-1:0]        i_now_ms,
    input  sdtq_pkg::t_dp_cmd           i_dp_cmd,
    output sdtq_pkg::t_dp_status        o_dp_status,
    output logic [sdtq_pkg::TMO_W-1:0]  o_timeout_ms,
    output logic [sdtq_pkg::ID_W-1:0]   o_head_id,
    output logic                        o_queue_empty,
    output logic [1:0]                  o_status
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL   = $clog2(QUEUE_DEPTH);

    logic [1:0]                         r_mode;
    logic [sdtq_pkg::ID_W-1:0]          r_id;
    logic [TIME_BITS-1:0]               r_end;
    logic [TIME_BITS-1:0]               r_now;
    logic [TIME_BITS-1:0]               r_dl  [QUEUE_DEPTH];
    logic [sdtq_pkg::ID_W-1:0]          r_sid [QUEUE_DEPTH];
    logic [CNT_W-1:0]                   r_count;
    logic [sdtq_pkg::NUM_TIMERS-1:0]    r_mask;
    logic [sdtq_pkg::TMO_W-1:0]         r_timeout;
    logic [sdtq_pkg::ID_W-1:0]          r_head;
    logic                               r_empty;
    logic [1:0]                         r_status;

    logic [TIME_BITS:0]                 sum;
    logic [TIME_BITS-1:0]               n_end;
    logic [QUEUE_DEPTH-1:0]             gt;
    logic [QUEUE_DEPTH-1:0]             match;
    logic [QUEUE_DEPTH-1:0]             pre [LVL+1];
    logic [TIME_BITS-1:0]               rem;
    logic [sdtq_pkg::TMO_W-1:0]         n_timeout;

    // deadline with saturation
    always_comb begin
        sum   = {1'b0, i_now_ms} + {1'b0, TIME_BITS'(i_duration_ms)};
        n_end = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_mode <= i_mode;
            r_id   <= i_timer_id;
            r_end  <= n_end;
            r_now  <= i_now_ms;
        end
    end

    // per-slot compares and prefix of the matching slot
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            gt[i]    = (CNT_W'(i) >= r_count) || (r_dl[i] > r_end);
            match[i] = (CNT_W'(i) < r_count) && (r_sid[i] == r_id);
        end
        pre[0] = match;
        for (int l = 0; l < LVL; l++) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
                end else begin
                    pre[l+1][i] = pre[l][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_dp_cmd.insert && gt[i]) begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                    r_dl[i]  <= r_dl[(i > 0) ? i - 1 : 0];
                    r_sid[i] <= r_sid[(i > 0) ? i - 1 : 0];
                end else begin
                    r_dl[i]  <= r_end;
                    r_sid[i] <= r_id;
                end
            end else if (i_dp_cmd.remove && pre[LVL][i] && i < QUEUE_DEPTH - 1) begin
                r_dl[i]  <= r_dl[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                r_sid[i] <= r_sid[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mask  <= '0;
        end else if (i_dp_cmd.insert) begin
            r_count      <= r_count + CNT_W'(1);
            r_mask[r_id] <= 1'b1;
        end else if (i_dp_cmd.remove) begin
            r_count      <= r_count - CNT_W'(1);
            r_mask[r_id] <= 1'b0;
        end
    end

    // remaining time of the head entry
    always_comb begin
        rem = r_dl[0] - r_now;
        if (r_count == '0) begin
            n_timeout = sdtq_pkg::TIMEOUT_EMPTY;
        end else if (r_now >= r_dl[0]) begin
            n_timeout = '0;
        end else if (rem > TIME_BITS'(sdtq_pkg::TIMEOUT_MAX)) begin
            n_timeout = sdtq_pkg::TIMEOUT_MAX;
        end else begin
            n_timeout = rem[sdtq_pkg::TMO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.report) begin
            r_timeout <= n_timeout;
            r_head    <= (r_count == '0) ? '0 : r_sid[0];
            r_empty   <= (r_count == '0);
            r_status  <= i_dp_cmd.status;
        end
    end

    assign o_dp_status.mode    = r_mode;
    assign o_dp_status.running = r_mask[r_id];
    assign o_dp_status.full    = (r_count >= CNT_W'(QUEUE_DEPTH));
    assign o_timeout_ms        = r_timeout;
    assign o_head_id           = r_head;
    assign o_queue_empty       = r_empty;
    assign o_status            = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_mask_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_mask) == int'(r_count))
        else $error("running mask disagrees with occupancy");

endmodule

### hw/rtl/sorted_deadline_timer_queue.sv
// top level of the sorted deadline timer queue
// the result is registered in the report step, which follows the load and queue-update steps
// a new command item is accepted only once the previous one has passed load, queue update and report
// a result still waiting at the output holds the report step until it is taken
// synchronous active-low reset clears occupancy, running mask and handshake state
// slot contents are not cleared; only occupied slots are ever read
`timescale 1ns / 1ps

module sorted_deadline_timer_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdtq_cmd_if.sink   i_cmd,
    sdtq_res_if.source o_res
);

    sdtq_pkg::t_dp_cmd    dp_cmd;
    sdtq_pkg::t_dp_status dp_status;

    sdtq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_dp_status (dp_status),
        .o_dp_cmd    (dp_cmd)
    );

    sdtq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_cmd.mode),
        .i_timer_id    (i_cmd.timer_id),
        .i_duration_ms (i_cmd.duration_ms),
        .i_now_ms      (i_cmd.now_ms),
        .i_dp_cmd      (dp_cmd),
        .o_dp_status   (dp_status),
        .o_timeout_ms  (o_res.timeout_ms),
        .o_head_id     (o_res.head_id),
        .o_queue_empty (o_res.queue_empty),
        .o_status      (o_res.status)
    );

endmodule

### bench/timer_check_pkg.sv
// deadline queue predictor and result checker for the timer queue bench
`timescale 1ns / 1ps

package timer_check_pkg;

    import sdtq_pkg::*;

    localparam int          TIME_W     = 48;
    localparam int          SLOTS      = 16;
    localparam logic [1:0]  MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [TMO_W-1:0] timeout_ms;
        logic [ID_W-1:0]  head_id;
        logic             queue_empty;
        logic [1:0]       status;
    } head_report_t;

    class timer_queue_tracker;

        logic [TIME_W-1:0] deadline [SLOTS];
        logic [ID_W-1:0]   owner [SLOTS];
        int unsigned       used;
        logic [NUM_TIMERS-1:0] running;
        head_report_t      pending_reports[$];
        int unsigned       faults;

        function new();
            used    = 0;
            running = '0;
            faults  = 0;
        endfunction

        function int unsigned waiting();
            return pending_reports.size();
        endfunction

        function void note_command(logic [1:0] mode, logic [ID_W-1:0] id,
                                   logic [DUR_W-1:0] dur, logic [TIME_W-1:0] now);
            head_report_t      rep;
            logic [TIME_W:0]   sum;
            logic [TIME_W-1:0] due;
            logic [TIME_W-1:0] gap;
            int                pos;
            int                k;

            rep.status = STATUS_OK;
            if (mode == MODE_START) begin
                if (running[id]) begin
                    rep.status = STATUS_RUNNING;
                end else if (used >= SLOTS) begin
                    rep.status = STATUS_FULL;
                end else begin
                    sum = {1'b0, now} + (TIME_W + 1)'(dur);
                    due = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    pos = 0;
                    while (pos < int'(used) && deadline[pos] <= due) pos++;
                    for (k = int'(used); k > pos; k--) begin
                        deadline[k] = deadline[k-1];
                        owner[k]    = owner[k-1];
                    end
                    deadline[pos] = due;
                    owner[pos]    = id;
                    used++;
                    running[id] = 1'b1;
                end
            end else if (mode == MODE_STOP) begin
                if (!running[id]) begin
                    rep.status = STATUS_NOT_RUNNG;
                end else begin
                    running[id] = 1'b0;
                    for (pos = 0; pos < int'(used); pos++) begin
                        if (owner[pos] == id) begin
                            for (k = pos; k + 1 < int'(used); k++) begin
                                deadline[k] = deadline[k+1];
                                owner[k]    = owner[k+1];
                            end
                            used--;
                            break;
                        end
                    end
                end
            end

            if (used == 0) begin
                rep.timeout_ms  = TIMEOUT_EMPTY;
                rep.head_id     = '0;
                rep.queue_empty = 1'b1;
            end else begin
                rep.head_id     = owner[0];
                rep.queue_empty = 1'b0;
                rep.timeout_ms  = '0;
                if (now < deadline[0]) begin
                    gap = deadline[0] - now;
                    rep.timeout_ms = (gap > TIME_W'(TIMEOUT_MAX)) ? TIMEOUT_MAX
                                                                  : gap[TMO_W-1:0];
                end
            end
            pending_reports.push_back(rep);
        endfunction

        function void flag(string field, logic [TMO_W-1:0] want, logic [TMO_W-1:0] got);
            faults++;
            if (faults <= 10)
                $display("[%0t] %s mismatch: expected %0h, got %0h", $time, field, want, got);
        endfunction

        function void check_report(head_report_t got);
            head_report_t want;

            if (pending_reports.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("[%0t] result with no command outstanding: %0h/%0h/%0h/%0h",
                             $time, got.timeout_ms, got.head_id, got.queue_empty, got.status);
                return;
            end
            want = pending_reports.pop_front();
            if (got.timeout_ms !== want.timeout_ms)
                flag("timeout_ms", want.timeout_ms, got.timeout_ms);
            if (got.head_id !== want.head_id)
                flag("head_id", TMO_W'(want.head_id), TMO_W'(got.head_id));
            if (got.queue_empty !== want.queue_empty)
                flag("queue_empty", TMO_W'(want.queue_empty), TMO_W'(got.queue_empty));
            if (got.status !== want.status)
                flag("status", TMO_W'(want.status), TMO_W'(got.status));
        endfunction

    endclass

endpackage

### bench/tb.sv
// top-level bench for the sorted deadline timer queue
`timescale 1ns / 1ps

module tb;

    import sdtq_pkg::*;
    import timer_check_pkg::*;

    logic i_clk;
    logic i_rst_n;

    sdtq_cmd_if #(.TIME_BITS(TIME_W)) cmd_ch ();
    sdtq_res_if                       res_ch ();

    timer_queue_tracker tracker = new();

    sorted_deadline_timer_queue #(
        .QUEUE_DEPTH (SLOTS),
        .TIME_BITS   (TIME_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_command(input logic [1:0] mode, input logic [ID_W-1:0] id,
                                input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] now);
        @(negedge i_clk);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= mode;
        cmd_ch.timer_id    <= id;
        cmd_ch.duration_ms <= dur;
        cmd_ch.now_ms      <= now;
        do @(posedge i_clk); while (!cmd_ch.ready);
        tracker.note_command(mode, id, dur, now);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            cmd_ch.valid <= 1'b0;
        end
    endtask

    task automatic wait_for_drain();
        idle_cycles(1);
        while (tracker.waiting() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // receiver stall pattern, one style per window
    initial begin
        int       style;
        logic [7:0] rot;

        res_ch.ready = 1'b0;
        rot = 8'b1011_0010;
        forever begin
            style = $urandom_range(0, 3);
            repeat (48) begin
                @(negedge i_clk);
                rot = {rot[6:0], rot[7]};
                case (style)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    2: res_ch.ready <= rot[0];
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            tracker.check_report({res_ch.timeout_ms, res_ch.head_id,
                                  res_ch.queue_empty, res_ch.status});
    end

    initial begin
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] now;
        logic [DUR_W-1:0]  dur;
        logic [1:0]        mode;
        int                pick;
        int                sent;
        int                burst;
        int                waited;
        bit                drain_late;

        cmd_ch.valid       = 1'b0;
        cmd_ch.mode        = MODE_QUERY;
        cmd_ch.timer_id    = '0;
        cmd_ch.duration_ms = '0;
        cmd_ch.now_ms      = '0;
        i_rst_n            = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue, idle stop, ties and saturation
        send_command(MODE_QUERY, 4'd0,  32'd0,         48'd0);
        send_command(MODE_SPARE, 4'd9,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_command(MODE_STOP,  4'd5,  32'd0,         48'd1000);
        send_command(MODE_START, 4'd0,  32'd0,         48'd1000);
        send_command(MODE_START, 4'd0,  32'd7,         48'd1000);
        send_command(MODE_START, 4'd1,  32'hFFFF_FFFF, 48'd1000);
        send_command(MODE_QUERY, 4'd0,  32'd0,         48'd0);
        send_command(MODE_STOP,  4'd0,  32'd0,         48'd1000);
        send_command(MODE_QUERY, 4'd0,  32'd0,         48'd0);
        send_command(MODE_START, 4'd15, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFF0);
        send_command(MODE_START, 4'd2,  32'd500,       48'hFFFF_FFFF_FFFF);
        send_command(MODE_START, 4'd3,  32'd100,       48'd2000);
        send_command(MODE_START, 4'd4,  32'd100,       48'd2000);
        send_command(MODE_STOP,  4'd3,  32'd0,         48'd2050);
        send_command(MODE_STOP,  4'd4,  32'd0,         48'd2050);
        for (int id = 0; id < NUM_TIMERS; id++)
            if (id != 1 && id != 2 && id != 15)
                send_command(MODE_START, ID_W'(id), DUR_W'($urandom_range(0, 3000)), 48'd2100);
        send_command(MODE_START, 4'd9,  32'd1,         48'd2100);
        send_command(MODE_QUERY, 4'd0,  32'd0,         48'd2100);

        wait_for_drain();

        clock_ms = TIME_W'({$urandom, $urandom} >> 20);
        sent     = 0;
        while (sent < 400) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < 400) begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    clock_ms = 48'hFFFF_FFFF_0000 | TIME_W'($urandom_range(0, 65535));
                else if (pick < 10)
                    clock_ms = clock_ms + TIME_W'($urandom_range(0, 1_000_000));
                else
                    clock_ms = clock_ms + TIME_W'($urandom_range(0, 60));
                now = clock_ms;
                if ($urandom_range(0, 9) == 0)
                    now = TIME_W'({$urandom, $urandom});

                pick = $urandom_range(0, 99);
                if (pick < 60)
                    dur = $urandom_range(0, 200);
                else if (pick < 80)
                    dur = $urandom_range(0, 100_000);
                else
                    dur = $urandom;

                pick = $urandom_range(0, 99);
                mode = (pick < 42) ? MODE_START :
                       (pick < 72) ? MODE_STOP  :
                       (pick < 95) ? MODE_QUERY : MODE_SPARE;

                send_command(mode, ID_W'($urandom_range(0, NUM_TIMERS - 1)), dur, now);
                sent++;
                burst--;
                if (sent == 200)
                    wait_for_drain();
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 8));
        end

        idle_cycles(1);
        waited = 0;
        while (tracker.waiting() != 0 && waited < 20_000) begin
            @(posedge i_clk);
            waited++;
        end
        drain_late = (tracker.waiting() != 0);
        repeat (20) @(posedge i_clk);

        if (!drain_late && tracker.waiting() == 0 && tracker.faults == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
